// ===== sv/maas_pkg.sv =====
// ----------------------------------------------------------------------------
// maas_pkg: shared types and constants of the multichannel ADC averager
// Register indexes, field widths and the packed result word layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package maas_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int OFFSET_W   = 11;
    localparam int SCALE_W    = 16;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 72;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MAX   = 3'd5;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [2:0]          pad;
        logic [PCT_W-1:0]    position_percent;
        logic [SCALE_W-1:0]  current_value;
        logic [SCALE_W-1:0]  voltage_value;
        logic [SAMPLE_W-1:0] avg_current;
        logic [SAMPLE_W-1:0] avg_voltage;
        logic [SAMPLE_W-1:0] avg_position;
    } result_t;

endpackage

// ===== sv/multichannel_adc_average_scaler.sv =====
// ----------------------------------------------------------------------------
// multichannel_adc_average_scaler: three-channel moving average and calibration
// Each word is accepted, then updates its ring by read-modify-write; no new word
// is taken until it is done. A round-closing word then runs three shared reciprocal
// multiplies, calibrate, a 7-step divider and the output load. Synchronous reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_adc_average_scaler #(
    parameter int SAMPLES = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input stream: tdata = {pad[5:0], sample[9:0]}
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [maas_pkg::S_TDATA_W-1:0]        s_tdata,
    // result stream: tdata = avg_position[9:0], avg_voltage[19:10],
    // avg_current[29:20], voltage_value[45:30], current_value[61:46],
    // position_percent[68:62], pad[71:69]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [maas_pkg::M_TDATA_W-1:0]        m_tdata,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [maas_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [maas_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int SW    = maas_pkg::SAMPLE_W;
    localparam int LOGS  = $clog2(SAMPLES);
    localparam int PW    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int DEPTH = 3 * SAMPLES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUMW  = SW + LOGS;
    // sum / SAMPLES as sum * ceil(2^SHIFT / SAMPLES) >> SHIFT, exact for every sum
    localparam int SHIFT = SUMW + LOGS;
    localparam int RECW  = SUMW + 1;
    localparam int PRW   = SUMW + RECW;
    localparam logic [RECW-1:0] RECIP = RECW'((2**SHIFT + SAMPLES - 1) / SAMPLES);
    localparam int CPW   = SW + maas_pkg::SCALE_W;     // calibration product
    localparam int NUMW  = 17;                         // (avg - min) * 100 < 2^17

    localparam logic [PW-1:0] LAST_POS = PW'(SAMPLES - 1);

    // sequencer codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RD      = 3'd1;
    localparam logic [2:0] ST_AVG_MUL = 3'd2;
    localparam logic [2:0] ST_AVG_SH  = 3'd3;
    localparam logic [2:0] ST_CAL     = 3'd4;
    localparam logic [2:0] ST_DIV     = 3'd5;
    localparam logic [2:0] ST_OUT     = 3'd6;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [2:0]                      state_reg, state_next;
    logic [1:0]                      chan_reg;
    logic [PW-1:0]                   pos_reg;
    logic                            full_reg;
    logic [1:0]                      k_reg;
    logic [2:0]                      div_cnt_reg;
    logic                            m_tvalid_reg;
    maas_pkg::result_t               result_reg;

    logic [SUMW-1:0]                 sum_reg [3];
    logic [1:0]                      sum_idx;
    logic [SUMW-1:0]                 sum_rd;
    logic [SUMW-1:0]                 sum_next;

    logic [SW-1:0]                   ring_mem [DEPTH];
    logic [SW-1:0]                   rd_data_reg;
    logic [AW-1:0]                   rd_addr;
    logic [AW-1:0]                   addr_reg;
    logic [SW-1:0]                   sample_reg;

    logic [PRW-1:0]                  prod_reg;
    logic [SW-1:0]                   avg_reg [3];

    logic [CPW-1:0]                  volt_prod_reg, curr_prod_reg;
    logic                            pos_low_reg, pos_high_reg;
    logic [NUMW-1:0]                 rem_reg, dsh_reg;
    logic [maas_pkg::PCT_W-1:0]      quot_reg;

    logic signed [maas_pkg::OFFSET_W-1:0] voff_reg, coff_reg;
    logic [maas_pkg::SCALE_W-1:0]    vscale_reg, cscale_reg;
    logic [SW-1:0]                   pmin_reg, pmax_reg;

    logic                            in_fire;
    logic                            out_load;
    logic signed [SW+1:0]            v_volt, v_curr;
    logic                            volt_ok, curr_ok;
    logic [SW-1:0]                   pos_diff, pos_den;
    logic [NUMW-1:0]                 pos_num;
    logic                            div_take;
    logic [maas_pkg::PCT_W-1:0]      pct_final;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = result_reg;

    // hold the finished word in ST_OUT until the output register is free
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voff_reg   <= '0;
            vscale_reg <= 16'd1024;
            coff_reg   <= '0;
            cscale_reg <= 16'd1024;
            pmin_reg   <= '0;
            pmax_reg   <= 10'd1023;
        end else if (cfg_valid && cfg_ready) begin
            // indexes past the list fall through and are dropped
            unique case (cfg_index)
                maas_pkg::REG_VOLTAGE_OFFSET: voff_reg   <= cfg_data[maas_pkg::OFFSET_W-1:0];
                maas_pkg::REG_VOLTAGE_SCALE:  vscale_reg <= cfg_data;
                maas_pkg::REG_CURRENT_OFFSET: coff_reg   <= cfg_data[maas_pkg::OFFSET_W-1:0];
                maas_pkg::REG_CURRENT_SCALE:  cscale_reg <= cfg_data;
                maas_pkg::REG_POSITION_MIN:   pmin_reg   <= cfg_data[SW-1:0];
                maas_pkg::REG_POSITION_MAX:   pmax_reg   <= cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sample ring: one write port, one registered read port.
    // Address = channel * SAMPLES + ring position.
    // ------------------------------------------------------------------
    assign rd_addr = AW'(chan_reg) * AW'(SAMPLES) + AW'(pos_reg);

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
        if (state_reg == ST_RD) begin
            ring_mem[addr_reg] <= sample_reg;
        end
    end

    // ------------------------------------------------------------------
    // Running sums: one read index, shared by the update and the averaging
    // ------------------------------------------------------------------
    assign sum_idx = (state_reg == ST_RD) ? chan_reg : k_reg;
    assign sum_rd  = sum_reg[sum_idx];

    // drop the oldest entry only once the rings are full; before that the
    // read data is an unwritten entry and must not reach the sum
    assign sum_next = sum_rd - (full_reg ? SUMW'(rd_data_reg) : '0) + SUMW'(sample_reg);

    // ------------------------------------------------------------------
    // Calibration and position datapath (combinational part of ST_CAL)
    // ------------------------------------------------------------------
    assign v_volt  = $signed({2'b00, avg_reg[1]}) + (SW+2)'(voff_reg);
    assign v_curr  = $signed({2'b00, avg_reg[2]}) + (SW+2)'(coff_reg);
    // inside (0, 1024): top two bits clear and low bits nonzero
    assign volt_ok = (v_volt[SW+1:SW] == 2'b00) && (v_volt[SW-1:0] != '0);
    assign curr_ok = (v_curr[SW+1:SW] == 2'b00) && (v_curr[SW-1:0] != '0);

    assign pos_diff = avg_reg[0] - pmin_reg;
    assign pos_den  = pmax_reg - pmin_reg;
    assign pos_num  = NUMW'(pos_diff) * NUMW'(maas_pkg::PCT_FULL);

    // restoring divider: quotient is below 128, so seven steps cover it
    assign div_take = (rem_reg >= dsh_reg);

    // order matters: at or below min wins over at or above max
    always_comb begin
        priority if (pos_low_reg) begin
            pct_final = '0;
        end else if (pos_high_reg) begin
            pct_final = maas_pkg::PCT_FULL;
        end else begin
            pct_final = quot_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                // a round closes on channel 2; it reports once the rings are full
                if ((chan_reg == 2'd2) && (full_reg || (pos_reg == LAST_POS))) begin
                    state_next = ST_AVG_MUL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_AVG_MUL: state_next = ST_AVG_SH;
            ST_AVG_SH: begin
                state_next = (k_reg == 2'd2) ? ST_CAL : ST_AVG_MUL;
            end
            ST_CAL: state_next = ST_DIV;
            ST_DIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chan_reg     <= '0;
            pos_reg      <= '0;
            full_reg     <= 1'b0;
            k_reg        <= '0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            sum_reg[0]   <= '0;
            sum_reg[1]   <= '0;
            sum_reg[2]   <= '0;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_RD) begin
                sum_reg[chan_reg] <= sum_next;
                // advance channel, and the ring position after channel 2
                if (chan_reg == 2'd2) begin
                    chan_reg <= '0;
                    if (pos_reg == LAST_POS) begin
                        pos_reg  <= '0;
                        full_reg <= 1'b1;
                    end else begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end else begin
                    chan_reg <= chan_reg + 1'b1;
                end
                k_reg <= '0;
            end

            if (state_reg == ST_AVG_SH) begin
                k_reg <= k_reg + 1'b1;
            end

            if (state_reg == ST_CAL) begin
                div_cnt_reg <= 3'd6;
            end else if (state_reg == ST_DIV) begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            sample_reg <= s_tdata[SW-1:0];
            addr_reg   <= rd_addr;
        end

        if (state_reg == ST_AVG_MUL) begin
            prod_reg <= PRW'(sum_rd) * PRW'(RECIP);
        end
        if (state_reg == ST_AVG_SH) begin
            avg_reg[k_reg] <= prod_reg[SHIFT +: SW];
        end

        if (state_reg == ST_CAL) begin
            volt_prod_reg <= volt_ok ? CPW'(v_volt[SW-1:0]) * CPW'(vscale_reg) : '0;
            curr_prod_reg <= curr_ok ? CPW'(v_curr[SW-1:0]) * CPW'(cscale_reg) : '0;
            pos_low_reg   <= (avg_reg[0] <= pmin_reg);
            pos_high_reg  <= (avg_reg[0] >= pmax_reg);
            rem_reg       <= pos_num;
            dsh_reg       <= {1'b0, pos_den, 6'b0};
            quot_reg      <= '0;
        end

        if (state_reg == ST_DIV) begin
            if (div_take) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[maas_pkg::PCT_W-2:0], div_take};
        end

        if (out_load) begin
            result_reg.pad              <= '0;
            result_reg.avg_position     <= avg_reg[0];
            result_reg.avg_voltage      <= avg_reg[1];
            result_reg.avg_current      <= avg_reg[2];
            result_reg.voltage_value    <= volt_prod_reg[CPW-1:SW];
            result_reg.current_value    <= curr_prod_reg[CPW-1:SW];
            result_reg.position_percent <= pct_final;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_chan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        chan_reg != 2'd3)
        else $error("channel index out of range");

    a_accept_to_rmw: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_RD))
        else $error("accepted word not followed by ring update");

    a_result_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> full_reg)
        else $error("result produced before rings were full");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (result_reg.position_percent <= maas_pkg::PCT_FULL))
        else $error("position percentage above full scale");
`endif

endmodule
